// File: sv/tpb_pkg.sv
package tpb_pkg;

    localparam int unsigned ChanWidth  = 8;
    localparam int unsigned ModeWidth  = 4;
    localparam int unsigned CfgIdxW    = 1;
    localparam int unsigned CfgDataW   = 8;

    localparam logic [ChanWidth-1:0] FireTint  = 8'h70;
    localparam logic [ChanWidth-1:0] Fx1Limit  = 8'd2;
    localparam logic [ChanWidth-1:0] AlphaMax  = 8'd255;
    localparam logic [ChanWidth-1:0] AlphaInit = 8'd128;

    localparam int unsigned FogScale  = 21;
    localparam int unsigned FogRecip  = 5243;
    localparam int unsigned FogShift  = 17;
    localparam int unsigned FogProdW  = 25;

    typedef enum logic [ModeWidth-1:0] {
        MODE_ALPHA   = 4'd0,
        MODE_QUARTER = 4'd1,
        MODE_EIGHTH  = 4'd2,
        MODE_HALF    = 4'd3,
        MODE_FIRE    = 4'd4,
        MODE_FX1     = 4'd5,
        MODE_THREEQ  = 4'd6,
        MODE_SHADE   = 4'd7,
        MODE_FUZZ    = 4'd8,
        MODE_FOG     = 4'd9,
        MODE_OPAQUE  = 4'd10
    } blend_mode_t;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_BLEND_MODE = 1'd0,
        CFG_ALPHA      = 1'd1
    } cfg_index_t;

    typedef logic [ChanWidth-1:0] chan_t;

    // (255 - a) * 84 / 100, as (255 - a) * 21 / 25 by reciprocal
    function automatic chan_t fog_rest(input chan_t a);
        logic [FogProdW-1:0] prod;
        begin
            prod = FogProdW'(AlphaMax - a) * FogProdW'(FogScale) * FogProdW'(FogRecip);
            fog_rest = prod[FogShift +: ChanWidth];
        end
    endfunction

    function automatic chan_t mix_channel(
        input blend_mode_t mode,
        input chan_t       s,
        input chan_t       d,
        input chan_t       a,
        input chan_t       rest,
        input chan_t       idx,
        input logic        fx1_translucent
    );
        logic [16:0] wsum;
        logic [10:0] nsum;
        logic [15:0] prod;
        chan_t       r;
        begin
            wsum = 17'd0;
            nsum = 11'd0;
            prod = 16'd0;
            case (mode)
                MODE_ALPHA:
                begin
                    wsum = 17'(d * (AlphaMax - a)) + 17'(s * a);
                    r    = wsum[15:8];
                end
                MODE_QUARTER:
                begin
                    nsum = 11'(d) * 11'd3 + 11'(s);
                    r    = nsum[9:2];
                end
                MODE_EIGHTH:
                begin
                    nsum = 11'(d) * 11'd7 + 11'(s);
                    r    = nsum[10:3];
                end
                MODE_FIRE:
                begin
                    nsum = 11'(d | ((s >> 1) & FireTint)) + 11'(s);
                    r    = nsum[8:1];
                end
                MODE_FX1:
                begin
                    nsum = 11'(d) + 11'(s);
                    r    = fx1_translucent ? nsum[8:1] : s;
                end
                MODE_THREEQ:
                begin
                    nsum = 11'(s) * 11'd3 + 11'(d);
                    r    = nsum[9:2];
                end
                MODE_SHADE:
                begin
                    prod = d * idx;
                    r    = prod[12:5];
                end
                MODE_FUZZ:
                begin
                    r = d - (d >> 3);
                end
                MODE_FOG:
                begin
                    wsum = 17'(d * rest) + 17'(s * a);
                    r    = wsum[15:8];
                end
                MODE_OPAQUE:
                begin
                    r = s;
                end
                default:
                begin
                    nsum = 11'(d) + 11'(s);
                    r    = nsum[8:1];
                end
            endcase
            mix_channel = r;
        end
    endfunction

endpackage

// File: sv/translucent_pixel_blender_core.sv
// RGB888 per-pixel compositing unit.
// Input channel: in_valid / in_ready carry one pixel beat: source colour,
// destination colour, texel palette index and translucency map byte.
// Output channel: out_valid / out_ready carry the new destination colour.
// Config port: cfg_we writes cfg_data into register cfg_index
// (0 blend mode, 1 alpha) on the same edge; write only while idle.
// Path: an accepted beat is held in the input register, then in the output register.
// Throughput: one pixel per clock while out_ready is high; the blend math
// for a pixel is combinational between the input and output registers.
// Stall: when out_ready is low the result holds; the input register still
// takes a beat while it is empty, then in_ready drops until the output
// drains. No beat is lost or repeated.
// Reset: both pipeline stages empty, blend mode half, alpha 128.
module translucent_pixel_blender_core (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [tpb_pkg::CfgIdxW-1:0]  cfg_index,
    input  logic [tpb_pkg::CfgDataW-1:0] cfg_data,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  tpb_pkg::chan_t           src_red,
    input  tpb_pkg::chan_t           src_green,
    input  tpb_pkg::chan_t           src_blue,
    input  tpb_pkg::chan_t           dst_red,
    input  tpb_pkg::chan_t           dst_green,
    input  tpb_pkg::chan_t           dst_blue,
    input  tpb_pkg::chan_t           source_index,
    input  tpb_pkg::chan_t           map_entry,
    output logic                     out_valid,
    input  logic                     out_ready,
    output tpb_pkg::chan_t           out_red,
    output tpb_pkg::chan_t           out_green,
    output tpb_pkg::chan_t           out_blue
);
    import tpb_pkg::*;

    blend_mode_t mode_reg;
    chan_t       alpha_reg;
    chan_t       fog_rest_reg;

    logic  in_valid_reg;
    chan_t sr_reg, sg_reg, sb_reg;
    chan_t dr_reg, dg_reg, db_reg;
    chan_t idx_reg, map_reg;

    logic  out_valid_reg;
    chan_t out_red_reg, out_green_reg, out_blue_reg;
    chan_t out_red_next, out_green_next, out_blue_next;

    logic  out_take;
    logic  fx1_translucent;
    chan_t diff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_HALF;
            alpha_reg    <= AlphaInit;
            fog_rest_reg <= fog_rest(AlphaInit);
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_BLEND_MODE:
                begin
                    mode_reg <= blend_mode_t'(cfg_data[ModeWidth-1:0]);
                end
                CFG_ALPHA:
                begin
                    alpha_reg    <= cfg_data[ChanWidth-1:0];
                    fog_rest_reg <= fog_rest(cfg_data[ChanWidth-1:0]);
                end
                default:
                begin
                end
            endcase
        end
    end

    assign out_take = !out_valid_reg || out_ready;
    assign in_ready = !in_valid_reg || out_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (out_take)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            sr_reg  <= src_red;
            sg_reg  <= src_green;
            sb_reg  <= src_blue;
            dr_reg  <= dst_red;
            dg_reg  <= dst_green;
            db_reg  <= dst_blue;
            idx_reg <= source_index;
            map_reg <= map_entry;
        end
        if (out_take && in_valid_reg)
        begin
            out_red_reg   <= out_red_next;
            out_green_reg <= out_green_next;
            out_blue_reg  <= out_blue_next;
        end
    end

    always_comb
    begin
        diff            = (idx_reg >= map_reg) ? (idx_reg - map_reg) : (map_reg - idx_reg);
        fx1_translucent = diff > Fx1Limit;
        out_red_next    = mix_channel(mode_reg, sr_reg, dr_reg, alpha_reg, fog_rest_reg,
                                      idx_reg, fx1_translucent);
        out_green_next  = mix_channel(mode_reg, sg_reg, dg_reg, alpha_reg, fog_rest_reg,
                                      idx_reg, fx1_translucent);
        out_blue_next   = mix_channel(mode_reg, sb_reg, db_reg, alpha_reg, fog_rest_reg,
                                      idx_reg, fx1_translucent);
    end

    assign out_valid = out_valid_reg;
    assign out_red   = out_red_reg;
    assign out_green = out_green_reg;
    assign out_blue  = out_blue_reg;

endmodule

// File: bench/blend_checker.sv
`timescale 1ns / 1ps

module blend_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [tpb_pkg::CfgIdxW-1:0]  cfg_index,
    input  logic [tpb_pkg::CfgDataW-1:0] cfg_data,
    input  logic                         in_valid,
    input  logic                         in_ready,
    input  tpb_pkg::chan_t               src_red,
    input  tpb_pkg::chan_t               src_green,
    input  tpb_pkg::chan_t               src_blue,
    input  tpb_pkg::chan_t               dst_red,
    input  tpb_pkg::chan_t               dst_green,
    input  tpb_pkg::chan_t               dst_blue,
    input  tpb_pkg::chan_t               source_index,
    input  tpb_pkg::chan_t               map_entry,
    input  logic                         out_valid,
    input  logic                         out_ready,
    input  tpb_pkg::chan_t               out_red,
    input  tpb_pkg::chan_t               out_green,
    input  tpb_pkg::chan_t               out_blue,
    output int                           errors,
    output int                           pending
);

    import tpb_pkg::*;

    localparam int unsigned FogNum     = 84;
    localparam int unsigned FogDen     = 100;
    localparam int unsigned ShadeShift = 5;
    localparam int unsigned FuzzShift  = 3;

    typedef struct packed {
        chan_t red;
        chan_t green;
        chan_t blue;
    } rgb_t;

    logic [ModeWidth-1:0] cur_mode;
    chan_t                cur_alpha;
    rgb_t                 expected_pixels[$];

    initial
    begin
        errors   = 0;
        pending  = 0;
    end

    function automatic chan_t blend_channel(
        input logic [ModeWidth-1:0] mode,
        input chan_t                s,
        input chan_t                d,
        input chan_t                a,
        input chan_t                idx,
        input logic                 far
    );
        logic [31:0] sv;
        logic [31:0] dv;
        logic [31:0] av;
        logic [31:0] rest;
        logic [31:0] r;
        begin
            sv   = 32'(s);
            dv   = 32'(d);
            av   = 32'(a);
            rest = ((32'(AlphaMax) - av) * FogNum) / FogDen;
            case (mode)
                MODE_ALPHA:   r = (dv * (32'(AlphaMax) - av) + sv * av) >> 8;
                MODE_QUARTER: r = (3 * dv + sv) >> 2;
                MODE_EIGHTH:  r = (7 * dv + sv) >> 3;
                MODE_FIRE:    r = ((dv | ((sv >> 1) & 32'(FireTint))) + sv) >> 1;
                MODE_FX1:     r = far ? (dv + sv) >> 1 : sv;
                MODE_THREEQ:  r = (3 * sv + dv) >> 2;
                MODE_SHADE:   r = (dv * 32'(idx)) >> ShadeShift;
                MODE_FUZZ:    r = dv - (dv >> FuzzShift);
                MODE_FOG:     r = (dv * rest + sv * av) >> 8;
                MODE_OPAQUE:  r = sv;
                default:      r = (dv + sv) >> 1;
            endcase
            blend_channel = r[7:0];
        end
    endfunction

    function automatic rgb_t predict_pixel();
        chan_t diff;
        logic  far;
        rgb_t  p;
        begin
            diff    = (source_index >= map_entry) ? source_index - map_entry
                                                  : map_entry - source_index;
            far     = diff > Fx1Limit;
            p.red   = blend_channel(cur_mode, src_red, dst_red, cur_alpha, source_index, far);
            p.green = blend_channel(cur_mode, src_green, dst_green, cur_alpha,
                                    source_index, far);
            p.blue  = blend_channel(cur_mode, src_blue, dst_blue, cur_alpha, source_index, far);
            predict_pixel = p;
        end
    endfunction

    task automatic check_channel(input string name, input chan_t want, input chan_t got);
        begin
            if (want !== got)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %02h, actual %02h",
                         $time, name, want, got);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_mode  <= MODE_HALF;
            cur_alpha <= AlphaInit;
            expected_pixels.delete();
            pending = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_BLEND_MODE)
                    cur_mode <= cfg_data[ModeWidth-1:0];
                else
                    cur_alpha <= cfg_data;
            end
            if (in_valid && in_ready)
                expected_pixels.push_back(predict_pixel());
            if (out_valid && out_ready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected beat, expected none, actual %02h %02h %02h",
                             $time, out_red, out_green, out_blue);
                end
                else
                begin
                    check_channel("red", expected_pixels[0].red, out_red);
                    check_channel("green", expected_pixels[0].green, out_green);
                    check_channel("blue", expected_pixels[0].blue, out_blue);
                    void'(expected_pixels.pop_front());
                end
            end
            pending = expected_pixels.size();
        end
    end

endmodule

// File: bench/translucent_pixel_blender_core_test.sv
`timescale 1ns / 1ps

module translucent_pixel_blender_core_test;

    import tpb_pkg::*;

    localparam int CycleLimit   = 200000;
    localparam int RandPhases   = 25;
    localparam int PhaseItems   = 50;
    localparam int MaxGap       = 12;
    localparam int DrainCycles  = 4;

    typedef struct packed {
        chan_t sr;
        chan_t sg;
        chan_t sb;
        chan_t dr;
        chan_t dg;
        chan_t db;
        chan_t idx;
        chan_t map;
    } pixel_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                cfg_we;
    logic [CfgIdxW-1:0]  cfg_index;
    logic [CfgDataW-1:0] cfg_data;
    logic                in_valid;
    logic                in_ready;
    chan_t               src_red;
    chan_t               src_green;
    chan_t               src_blue;
    chan_t               dst_red;
    chan_t               dst_green;
    chan_t               dst_blue;
    chan_t               source_index;
    chan_t               map_entry;
    logic                out_valid;
    logic                out_ready = 1'b0;
    chan_t               out_red;
    chan_t               out_green;
    chan_t               out_blue;

    int errors;
    int pending;
    int cycle_count = 0;
    int stall_left  = 0;
    int rx_beats    = 0;
    bit rx_quiet    = 1'b0;

    always #6 clk = ~clk;

    translucent_pixel_blender_core u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .src_red      (src_red),
        .src_green    (src_green),
        .src_blue     (src_blue),
        .dst_red      (dst_red),
        .dst_green    (dst_green),
        .dst_blue     (dst_blue),
        .source_index (source_index),
        .map_entry    (map_entry),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_red      (out_red),
        .out_green    (out_green),
        .out_blue     (out_blue)
    );

    blend_checker u_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .src_red      (src_red),
        .src_green    (src_green),
        .src_blue     (src_blue),
        .dst_red      (dst_red),
        .dst_green    (dst_green),
        .dst_blue     (dst_blue),
        .source_index (source_index),
        .map_entry    (map_entry),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_red      (out_red),
        .out_green    (out_green),
        .out_blue     (out_blue),
        .errors       (errors),
        .pending      (pending)
    );

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // hold off the result side for a random number of cycles after each beat
    always @(negedge clk)
        out_ready <= rst_n && (stall_left == 0);

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            rx_beats = rx_beats + 1;
            if (rx_beats % PhaseItems == 0)
                rx_quiet = ($urandom_range(0, 3) == 0);
            stall_left <= rx_quiet ? 0 : $urandom_range(0, MaxGap);
        end
        else if (stall_left > 0)
            stall_left <= stall_left - 1;
    end

    function automatic chan_t pick_chan();
        begin
            case ($urandom_range(0, 7))
                0:       pick_chan = 8'h00;
                1:       pick_chan = 8'hFF;
                default: pick_chan = 8'($urandom);
            endcase
        end
    endfunction

    function automatic pixel_t random_pixel();
        pixel_t p;
        begin
            p.sr  = pick_chan();
            p.sg  = pick_chan();
            p.sb  = pick_chan();
            p.dr  = pick_chan();
            p.dg  = pick_chan();
            p.db  = pick_chan();
            p.idx = pick_chan();
            // keep the map byte near the index half the time to straddle the fx1 limit
            if ($urandom_range(0, 1) == 0)
                p.map = p.idx + 8'($urandom_range(0, 8)) - 8'd4;
            else
                p.map = pick_chan();
            random_pixel = p;
        end
    endfunction

    function automatic pixel_t flat_pixel(input chan_t v, input chan_t idx, input chan_t map);
        begin
            flat_pixel = '{v, v, v, v, v, v, idx, map};
        end
    endfunction

    task automatic send_pixel(input pixel_t p, input int gap);
        begin
            @(negedge clk);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            in_valid     <= 1'b1;
            src_red      <= p.sr;
            src_green    <= p.sg;
            src_blue     <= p.sb;
            dst_red      <= p.dr;
            dst_green    <= p.dg;
            dst_blue     <= p.db;
            source_index <= p.idx;
            map_entry    <= p.map;
            do
                @(posedge clk);
            while (!in_ready);
        end
    endtask

    task automatic drain_results();
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            while (pending != 0)
                @(negedge clk);
            repeat (DrainCycles) @(negedge clk);
        end
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CfgDataW-1:0] data);
        begin
            @(negedge clk);
            cfg_we    <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= data;
            @(negedge clk);
            cfg_we    <= 1'b0;
        end
    endtask

    task automatic set_blend(input logic [CfgDataW-1:0] mode_data, input chan_t alpha_val);
        begin
            write_reg(CFG_BLEND_MODE, mode_data);
            write_reg(CFG_ALPHA, alpha_val);
        end
    endtask

    initial
    begin
        int                  m;
        int                  p;
        int                  n;
        bit                  tx_quiet;
        logic [CfgDataW-1:0] mode_data;
        chan_t               alpha_val;

        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = CFG_BLEND_MODE;
        cfg_data     = '0;
        in_valid     = 1'b0;
        src_red      = '0;
        src_green    = '0;
        src_blue     = '0;
        dst_red      = '0;
        dst_green    = '0;
        dst_blue     = '0;
        source_index = '0;
        map_entry    = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings first, then every mode plus an unused code at both ends of the range
        send_pixel('{8'h12, 8'h34, 8'h56, 8'hFE, 8'h01, 8'h80, 8'h40, 8'h41}, 0);
        drain_results();
        for (m = 0; m <= int'(MODE_OPAQUE) + 1; m++)
        begin
            mode_data = (m > int'(MODE_OPAQUE)) ? 8'hFC : 8'(m);
            set_blend(mode_data, (m % 2 == 0) ? 8'hFF : 8'h00);
            send_pixel(flat_pixel(8'h00, 8'h00, 8'h00), 0);
            send_pixel(flat_pixel(8'hFF, 8'hFF, 8'hFF), 1);
            if (m == int'(MODE_FX1))
            begin
                send_pixel('{8'hC8, 8'h64, 8'h0A, 8'h10, 8'hF0, 8'h7F, 8'd10, 8'd12}, 0);
                send_pixel('{8'hC8, 8'h64, 8'h0A, 8'h10, 8'hF0, 8'h7F, 8'd12, 8'd9}, 0);
            end
            drain_results();
        end

        for (p = 0; p < RandPhases; p++)
        begin
            if (p < 2 * (int'(MODE_OPAQUE) + 1))
                mode_data = 8'(p % (int'(MODE_OPAQUE) + 1));
            else
                mode_data = 8'($urandom_range(0, 15));
            mode_data[CfgDataW-1:ModeWidth] = 4'($urandom_range(0, 15));
            case ($urandom_range(0, 3))
                0:       alpha_val = 8'h00;
                1:       alpha_val = 8'hFF;
                default: alpha_val = 8'($urandom);
            endcase
            set_blend(mode_data, alpha_val);
            tx_quiet = ($urandom_range(0, 3) == 0);
            for (n = 0; n < PhaseItems; n++)
                send_pixel(random_pixel(), tx_quiet ? 0 : $urandom_range(0, MaxGap));
            drain_results();
        end

        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
